FILE: rtl/aot_pkg.sv
// aot_pkg: shared types and constants of the audio onset trigger
// no dependencies; imported by the interfaces and every rtl module

package aot_pkg;

  // field widths
  localparam int SMP_W   = 24;
  localparam int MAG_W   = 23;
  localparam int COEF_W  = 24;
  localparam int THR_W   = 23;
  localparam int HOLD_W  = 20;
  localparam int CIDX_W  = 4;
  localparam int CDATA_W = 24;

  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

  // register indexes on the configuration channel
  localparam logic [CIDX_W-1:0] REG_FAST_ATTACK  = 4'd0;
  localparam logic [CIDX_W-1:0] REG_FAST_RELEASE = 4'd1;
  localparam logic [CIDX_W-1:0] REG_SLOW_ATTACK  = 4'd2;
  localparam logic [CIDX_W-1:0] REG_SLOW_RELEASE = 4'd3;
  localparam logic [CIDX_W-1:0] REG_NOVELTY      = 4'd4;
  localparam logic [CIDX_W-1:0] REG_HIGH_THR     = 4'd5;
  localparam logic [CIDX_W-1:0] REG_LOW_THR      = 4'd6;
  localparam logic [CIDX_W-1:0] REG_COOLDOWN     = 4'd7;

  // register reset values
  localparam logic [COEF_W-1:0] RST_FAST_ATTACK  = 24'd16603360;
  localparam logic [COEF_W-1:0] RST_FAST_RELEASE = 24'd16765569;
  localparam logic [COEF_W-1:0] RST_SLOW_ATTACK  = 24'd16772848;
  localparam logic [COEF_W-1:0] RST_SLOW_RELEASE = 24'd16775968;
  localparam logic [COEF_W-1:0] RST_NOVELTY      = 24'd16768480;
  localparam logic [THR_W-1:0]  RST_HIGH_THR     = 23'd293601;
  localparam logic [THR_W-1:0]  RST_LOW_THR      = 23'd167772;
  localparam logic [HOLD_W-1:0] RST_COOLDOWN     = 20'd16800;

  typedef struct packed {
    logic [COEF_W-1:0] fast_attack;
    logic [COEF_W-1:0] fast_release;
    logic [COEF_W-1:0] slow_attack;
    logic [COEF_W-1:0] slow_release;
    logic [COEF_W-1:0] novelty;
    logic [THR_W-1:0]  high_thr;
    logic [THR_W-1:0]  low_thr;
    logic [HOLD_W-1:0] cooldown;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FAST,
    ST_SLOW,
    ST_SLOW_WB,
    ST_NOV,
    ST_NOV_WB
  } state_t;

  typedef enum logic [1:0] {
    SEL_FAST,
    SEL_SLOW,
    SEL_NOV
  } mul_sel_t;

  // commands from controller to datapath
  typedef struct packed {
    logic     load_mag;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     wb_fast;
    logic     wb_slow;
    logic     wb_nov;
  } cmd_t;

endpackage

FILE: rtl/aot_if.sv
// aot_if: valid/ready channel interfaces for samples, results and config writes
// depends on aot_pkg for field widths

interface aot_smp_if import aot_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface aot_res_if import aot_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             event_res;
  logic [MAG_W-1:0] novelty_level;

  modport source (output valid, output event_res, output novelty_level, input ready);
  modport sink (input valid, input event_res, input novelty_level, output ready);
endinterface

interface aot_cfg_if import aot_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CIDX_W-1:0]  index;
  logic [CDATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/aot_regs.sv
// aot_regs: configuration register file of the onset trigger
// depends on aot_pkg for register indexes, reset values and cfg_t

module aot_regs import aot_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [CIDX_W-1:0]  wr_index,
  input  logic [CDATA_W-1:0] wr_data,
  output cfg_t               cfg
);

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fast_attack  <= RST_FAST_ATTACK;
      cfg.fast_release <= RST_FAST_RELEASE;
      cfg.slow_attack  <= RST_SLOW_ATTACK;
      cfg.slow_release <= RST_SLOW_RELEASE;
      cfg.novelty      <= RST_NOVELTY;
      cfg.high_thr     <= RST_HIGH_THR;
      cfg.low_thr      <= RST_LOW_THR;
      cfg.cooldown     <= RST_COOLDOWN;
    end else if (wr_en) begin
      case (wr_index)
        REG_FAST_ATTACK:  cfg.fast_attack  <= wr_data[COEF_W-1:0];
        REG_FAST_RELEASE: cfg.fast_release <= wr_data[COEF_W-1:0];
        REG_SLOW_ATTACK:  cfg.slow_attack  <= wr_data[COEF_W-1:0];
        REG_SLOW_RELEASE: cfg.slow_release <= wr_data[COEF_W-1:0];
        REG_NOVELTY:      cfg.novelty      <= wr_data[COEF_W-1:0];
        REG_HIGH_THR:     cfg.high_thr     <= wr_data[THR_W-1:0];
        REG_LOW_THR:      cfg.low_thr      <= wr_data[THR_W-1:0];
        REG_COOLDOWN:     cfg.cooldown     <= wr_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/aot_ctrl.sv
// aot_ctrl: sequencer that steps one sample through the shared multiplier
// depends on aot_pkg for state_t and cmd_t

module aot_ctrl import aot_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  state_t state, state_next;
  logic   out_valid_next;

  // state and output-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.mul_sel = SEL_FAST;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_mag = 1'b1;
          state_next   = ST_FAST;
        end
      end
      ST_FAST: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = SEL_FAST;
        state_next  = ST_SLOW;
      end
      ST_SLOW: begin
        cmd.wb_fast = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = SEL_SLOW;
        state_next  = ST_SLOW_WB;
      end
      ST_SLOW_WB: begin
        cmd.wb_slow = 1'b1;
        state_next  = ST_NOV;
      end
      ST_NOV: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = SEL_NOV;
        state_next  = ST_NOV_WB;
      end
      ST_NOV_WB: begin
        // hold here while the previous result is still unclaimed
        if (!out_valid || out_ready) begin
          cmd.wb_nov = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    // result register occupancy
    if (cmd.wb_nov) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

FILE: rtl/aot_dp.sv
// aot_dp: envelope, novelty and hysteresis datapath with one shared multiplier
// depends on aot_pkg for cfg_t, cmd_t and widths

module aot_dp import aot_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  input  cfg_t                    cfg,
  input  logic signed [SMP_W-1:0] sample,
  output logic                    event_res,
  output logic [MAG_W-1:0]        novelty_level
);

  localparam int PROD_W = COEF_W + MAG_W + 2;

  // rounding and clamp after the multiply: x + floor((p + 2^23) / 2^24)
  function automatic logic [MAG_W-1:0] pole_finish(
    input logic signed [PROD_W-1:0] p,
    input logic [MAG_W-1:0]         x
  );
    logic signed [PROD_W-1:0]        sum;
    logic signed [PROD_W-COEF_W-1:0] t;
    logic signed [PROD_W-COEF_W+1:0] r;
    sum = p + PROD_W'(1 << (COEF_W - 1));
    t   = sum[PROD_W-1:COEF_W];
    r   = $signed({4'b0000, x}) + $signed({{2{t[PROD_W-COEF_W-1]}}, t});
    if (r[PROD_W-COEF_W+1]) begin
      return '0;
    end else if (r > $signed({4'b0000, MAG_MAX})) begin
      return MAG_MAX;
    end else begin
      return r[MAG_W-1:0];
    end
  endfunction

  logic [MAG_W-1:0]         mag;
  logic [MAG_W-1:0]         fast_env;
  logic [MAG_W-1:0]         slow_env;
  logic [MAG_W-1:0]         nov;
  logic [HOLD_W-1:0]        hold_cnt;
  logic                     active;
  logic [MAG_W-1:0]         pole_x;
  logic signed [PROD_W-1:0] prod;

  logic [SMP_W-1:0]         raw;
  logic [SMP_W-1:0]         neg;
  logic [MAG_W-1:0]         mag_next;
  logic [MAG_W-1:0]         delta;
  logic [MAG_W-1:0]         mx;
  logic [MAG_W-1:0]         my;
  logic [COEF_W-1:0]        ma;
  logic signed [MAG_W:0]    md;
  logic signed [PROD_W-1:0] mul_a;
  logic signed [PROD_W-1:0] mul_b;
  logic [MAG_W-1:0]         nov_next;

  // rectify with saturation of the most negative code
  always_comb begin
    raw = sample;
    neg = '0 - raw;
    if (!raw[SMP_W-1]) begin
      mag_next = raw[MAG_W-1:0];
    end else if (neg[SMP_W-1]) begin
      mag_next = MAG_MAX;
    end else begin
      mag_next = neg[MAG_W-1:0];
    end
  end

  // positive envelope difference
  assign delta = (fast_env > slow_env) ? fast_env - slow_env : '0;

  // multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      SEL_FAST: begin
        mx = mag;
        my = fast_env;
        ma = (mag > fast_env) ? cfg.fast_attack : cfg.fast_release;
      end
      SEL_SLOW: begin
        mx = mag;
        my = slow_env;
        ma = (mag > slow_env) ? cfg.slow_attack : cfg.slow_release;
      end
      SEL_NOV: begin
        mx = delta;
        my = nov;
        ma = cfg.novelty;
      end
      default: begin
        mx = mag;
        my = fast_env;
        ma = cfg.fast_attack;
      end
    endcase
    md = $signed({1'b0, my}) - $signed({1'b0, mx});
    // operands sign-extended to the full product width
    mul_a = PROD_W'($signed({1'b0, ma}));
    mul_b = PROD_W'(md);
  end

  assign nov_next = pole_finish(prod, pole_x);

  // magnitude, product and pole input registers
  always_ff @(posedge clk) begin
    if (cmd.load_mag) begin
      mag <= mag_next;
    end
    if (cmd.mul_en) begin
      prod   <= mul_a * mul_b;
      pole_x <= mx;
    end
  end

  // filter state and hysteresis
  always_ff @(posedge clk) begin
    if (rst) begin
      fast_env <= '0;
      slow_env <= '0;
      nov      <= '0;
      hold_cnt <= '0;
      active   <= 1'b0;
    end else begin
      if (cmd.wb_fast) begin
        fast_env <= pole_finish(prod, pole_x);
      end
      if (cmd.wb_slow) begin
        slow_env <= pole_finish(prod, pole_x);
      end
      if (cmd.wb_nov) begin
        nov <= nov_next;
        if (hold_cnt != '0) begin
          hold_cnt <= hold_cnt - 1'b1;
        end else if (!active && nov_next > cfg.high_thr) begin
          active   <= 1'b1;
          hold_cnt <= cfg.cooldown;
        end else if (active && nov_next < cfg.low_thr) begin
          active <= 1'b0;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.wb_nov) begin
      novelty_level <= nov_next;
      event_res     <= (hold_cnt == '0) && !active && (nov_next > cfg.high_thr);
    end
  end

endmodule

FILE: rtl/audio_onset_trigger_unit.sv
// audio onset trigger, top level: one signed Q1.23 sample in, one event flag
// and novelty level out. Channels: samples (sink), results (source) and a
// configuration write channel cfg (index 0..7, always ready; other indexes
// are dropped). The user must write configuration only while no sample is
// in flight; the block does not enforce this. Each accepted sample runs
// through one shared 25x24 multiplier three times (fast envelope, slow
// envelope, novelty), each pass followed by a rounding writeback; the
// result is registered at the last, and a new sample is taken only after it.
// The result sits in an output register, so the next sample is accepted
// while it waits. If results stalls, the next sample finishes its filter
// passes and then waits in its final step until the old result is taken.
// Reset (rst, synchronous) clears the envelopes, novelty, holdoff and event
// state and loads the default coefficients and thresholds.
// Depends on aot_pkg, aot_if, aot_regs, aot_ctrl and aot_dp.

module audio_onset_trigger_unit import aot_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  aot_smp_if.sink    samples,
  aot_res_if.source  results,
  aot_cfg_if.sink    cfg
);

  cfg_t cfg_regs;
  cmd_t cmd;

  assign cfg.ready = 1'b1;

  aot_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_regs)
  );

  aot_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .cmd       (cmd)
  );

  aot_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg           (cfg_regs),
    .sample        (samples.sample),
    .event_res     (results.event_res),
    .novelty_level (results.novelty_level)
  );

  // a request in flight blocks the next one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready |=> !samples.ready)
    else $error("sample accepted while previous one in flight");

  // novelty writeback always presents a result
  a_wb_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.wb_nov |=> results.valid)
    else $error("writeback without result valid");

  // at most one of load, multiply, slow and novelty writeback at a time
  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_mag, cmd.mul_en, cmd.wb_slow, cmd.wb_nov}))
    else $error("overlapping sequencer commands");

  // an event is only reported above the firing level
  a_event_level: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.event_res |-> results.novelty_level > cfg_regs.high_thr)
    else $error("event reported at or below high threshold");

endmodule
